[rtl/stt_pkg.sv]
package stt_pkg;

  localparam int OP_W    = 2;
  localparam int COUNT_W = 16;
  localparam int DEL_W   = 8;
  localparam int SLOT_W  = 4;

  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_FIND = 3'd1;
  localparam logic [ST_W-1:0] ST_READ = 3'd2;
  localparam logic [ST_W-1:0] ST_UPD  = 3'd3;
  localparam logic [ST_W-1:0] ST_FIN  = 3'd4;

  typedef struct packed {
    logic [COUNT_W-1:0] remaining;
    logic [COUNT_W-1:0] reload;
  } timer_entry_t;

endpackage

[rtl/software_timer_table.sv]
// Register: walks slots from 0 to the first free one, one slot per cycle; all full answers SLOTS.
// Delete: no result; the block stays ready.
// Tick: visits each slot in turn through one timer RAM, read and write on a shared address, and
// one decrementer, then closes; a firing waits on the output register while another is pending.
// Reset (rst, synchronous, active high) frees every slot and empties the output register.
module software_timer_table #(
  parameter int SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stt_pkg::OP_W-1:0]      operation,
  input  logic [stt_pkg::COUNT_W-1:0]   start_ticks,
  input  logic [stt_pkg::COUNT_W-1:0]   reload_period,
  input  logic [stt_pkg::DEL_W-1:0]     slot_to_delete,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          result_kind,
  output logic [stt_pkg::SLOT_W-1:0]    slot,
  output logic                          last
);
  import stt_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] FULL_SLOT = SLOT_W'(SLOTS);

  logic [ST_W-1:0]    state;
  logic [IW-1:0]      idx;
  logic [SLOTS-1:0]   active;
  logic [COUNT_W-1:0] start_hold;
  logic [COUNT_W-1:0] period_hold;
  logic               pend_valid;
  logic [SLOT_W-1:0]  pend_slot;

  logic               accept;
  logic               out_free;
  logic [SLOT_W-1:0]  idx_slot;
  logic               ram_we;
  timer_entry_t       ram_wdata;
  timer_entry_t       ram_rdata;
  logic [COUNT_W-1:0] dec;
  logic               fire;
  logic               upd_go;
  logic               del_hit;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign idx_slot = SLOT_W'(idx);
  assign del_hit  = ({1'b0, slot_to_delete} < 9'(SLOTS)) && active[slot_to_delete[IW-1:0]];

  assign dec    = (ram_rdata.remaining != '0) ? ram_rdata.remaining - 1'b1 : '0;
  assign fire   = (dec == '0);
  assign upd_go = !fire || !pend_valid || out_free;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '{remaining: start_hold, reload: period_hold};
    if (state == ST_FIND) begin
      ram_we = !active[idx] && out_free;
    end else if (state == ST_UPD && upd_go) begin
      if (!fire) begin
        ram_we    = 1'b1;
        ram_wdata = '{remaining: dec, reload: ram_rdata.reload};
      end else if (ram_rdata.reload != '0) begin
        ram_we    = 1'b1;
        ram_wdata = '{remaining: ram_rdata.reload, reload: ram_rdata.reload};
      end
    end
  end

  stt_ram #(
    .WIDTH($bits(timer_entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      active     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            idx <= '0;
            case (operation)
              OP_REGISTER: begin
                start_hold  <= start_ticks;
                period_hold <= reload_period;
                state       <= ST_FIND;
              end
              OP_DELETE: begin
                if (del_hit) begin
                  active[slot_to_delete[IW-1:0]] <= 1'b0;
                end
              end
              OP_TICK: begin
                pend_valid <= 1'b0;
                state      <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_FIND: begin
          if (!active[idx] || idx == LAST_IDX) begin
            if (out_free) begin
              active[idx] <= active[idx] | !active[idx];
              out_valid   <= 1'b1;
              result_kind <= KIND_ANSWER;
              slot        <= active[idx] ? FULL_SLOT : idx_slot;
              last        <= 1'b1;
              state       <= ST_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_READ: begin
          if (active[idx]) begin
            state <= ST_UPD;
          end else if (idx == LAST_IDX) begin
            state <= ST_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            if (fire) begin
              if (pend_valid) begin
                out_valid   <= 1'b1;
                result_kind <= KIND_EXPIRY;
                slot        <= pend_slot;
                last        <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_slot  <= idx_slot;
              if (ram_rdata.reload == '0) begin
                active[idx] <= 1'b0;
              end
            end
            if (idx == LAST_IDX) begin
              state <= ST_FIN;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_FIN: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            result_kind <= KIND_EXPIRY;
            slot        <= pend_slot;
            last        <= 1'b1;
            pend_valid  <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/stt_ram.sv]
module stt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/stt_check.sv]
module stt_check #(
  parameter int SLOTS = 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [stt_pkg::OP_W-1:0]      operation,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          result_kind,
  input logic [stt_pkg::SLOT_W-1:0]    slot,
  input logic                          last
);
  import stt_pkg::*;

  localparam logic [SLOT_W-1:0] FULL_SLOT = SLOT_W'(SLOTS);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && out_valid && out_stall |=>
      out_valid && $stable(result_kind) && $stable(slot) && $stable(last))
    else $error("stalled result changed");

  a_answer_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_ANSWER |-> last)
    else $error("register answer not marked last");

  a_answer_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_ANSWER |-> slot <= FULL_SLOT)
    else $error("register answer slot out of range");

  a_register_busy: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && !in_stall && operation == OP_REGISTER |=> in_stall)
    else $error("register request did not occupy the block");

  a_delete_ready: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && !in_stall && operation == OP_DELETE |=> !in_stall)
    else $error("delete request left the block busy");

endmodule

bind software_timer_table stt_check #(.SLOTS(SLOTS)) u_stt_check (.*);
